// File: rtl/aip_pkg.sv
package aip_pkg;

  // radix mode register codes
  localparam logic [2:0] MODE_AUTO = 3'd0;
  localparam logic [2:0] MODE_BIN  = 3'd1;
  localparam logic [2:0] MODE_OCT  = 3'd2;
  localparam logic [2:0] MODE_DEC  = 3'd3;
  localparam logic [2:0] MODE_HEX  = 3'd4;

  // ascii codes the parser looks for
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] HEX_BIAS = 8'h57;

  typedef enum logic [1:0] {
    PH_SIGN,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  // radix found by auto-detect
  typedef enum logic [1:0] {
    AR_NONE,
    AR_OCT,
    AR_DEC,
    AR_HEX
  } aradix_t;

  // radix in effect for one digit
  typedef enum logic [2:0] {
    RX_NONE,
    RX_BIN,
    RX_OCT,
    RX_DEC,
    RX_HEX
  } radix_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t aip_digit(input logic [7:0] c, input radix_t rx);
    digit_t     d;
    logic [7:0] low;
    logic [7:0] dv;
    logic [7:0] hv;
    low   = c | CH_CASE;
    dv    = c - CH_ZERO;
    hv    = low - HEX_BIAS;
    d.ok  = 1'b0;
    d.val = dv[3:0];
    unique case (rx)
      RX_BIN: d.ok = (c == CH_ZERO) || (c == CH_ONE);
      RX_OCT: d.ok = (c >= CH_ZERO) && (c <= CH_SEVEN);
      RX_DEC: d.ok = (c >= CH_ZERO) && (c <= CH_NINE);
      RX_HEX: begin
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
          d.ok = 1'b1;
        end else if ((low >= CH_LOW_A) && (low <= CH_LOW_F)) begin
          d.ok  = 1'b1;
          d.val = hv[3:0];
        end
      end
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/ascii_integer_parser_unit.sv
// ascii integer parser: takes the text of a number one byte per request on the
// slave stream (tlast marks the final byte) and gives one signed 64-bit value
// per number on the master stream, wrapped modulo 2^64 and negated for a
// leading minus. radix_mode selects auto-detect (decimal, 0-led octal, 0x hex),
// binary, octal (skips 0x or a leading 0), decimal or hex (skips 0x or #);
// codes 5 to 7 give zero. Digits stop at the first non-digit byte and the rest
// of the number is ignored. One byte is taken per cycle unless a last byte waits
// on a stalled result stage; the accumulate (shift, times-ten add and digit add)
// sits between the input register and the per-number result register, and the
// sign is applied in the output register. Write radix_mode only between numbers.
module ascii_integer_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data,   // radix_mode
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,    // char_byte
  input  logic               s_tlast,    // last_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic signed [63:0] m_tdata     // parsed_value
);
  import aip_pkg::*;

  logic [2:0] radix_mode;

  // input register
  logic       in_v;
  logic [7:0] in_char;
  logic       in_last;

  // parse state
  phase_t     phase, phase_next;
  logic       neg, neg_next;
  logic [63:0] acc, acc_next;
  logic       stopped, stopped_next;
  aradix_t    aradix, aradix_next;

  // finished number waiting for the sign
  logic        fin_v;
  logic [63:0] fin_acc;
  logic        fin_neg;

  logic   out_ready, fin_ready, proc_fire;
  logic   reserved, done, take, is_x;
  radix_t rx;
  digit_t dig;
  logic [63:0] acc_scaled;

  assign out_ready = !m_tvalid || m_tready;
  assign fin_ready = !fin_v || out_ready;
  // a byte that is not the last never needs the result stage
  assign proc_fire = in_v && (!in_last || fin_ready);
  assign s_tready  = !in_v || proc_fire;

  assign reserved = radix_mode > MODE_HEX;
  assign is_x     = (in_char | CH_CASE) == CH_LOW_X;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode <= MODE_AUTO;
    end else if (cfg_we) begin
      radix_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // next parse state for the byte in the input register
  always_comb begin
    phase_next   = phase;
    neg_next     = neg;
    stopped_next = stopped;
    aradix_next  = aradix;
    acc_next     = acc;
    done         = 1'b0;
    take         = 1'b0;
    rx           = RX_NONE;
    dig          = '0;
    acc_scaled   = '0;
    if (!reserved && !stopped) begin
      if (phase == PH_SIGN) begin
        phase_next = PH_PREFIX;
        if (in_char == CH_MINUS) begin
          neg_next = 1'b1;
          done     = 1'b1;
        end else if (in_char == CH_PLUS) begin
          done = 1'b1;
        end
      end
      if (!done) begin
        unique case (phase_next)
          PH_PREFIX: begin
            if (radix_mode == MODE_AUTO) begin
              if ((in_char >= CH_ONE) && (in_char <= CH_NINE)) begin
                aradix_next = AR_DEC;
                take        = 1'b1;
              end else if (in_char == CH_ZERO) begin
                phase_next = PH_ZERO;
              end else begin
                stopped_next = 1'b1;
              end
            end else if ((radix_mode == MODE_OCT) || (radix_mode == MODE_HEX)) begin
              if (in_char == CH_ZERO) begin
                phase_next = PH_ZERO;
              end else if ((radix_mode == MODE_HEX) && (in_char == CH_HASH)) begin
                phase_next = PH_DIGITS;
              end else begin
                take = 1'b1;
              end
            end else begin
              take = 1'b1;
            end
          end
          PH_ZERO: begin
            if (radix_mode == MODE_AUTO) begin
              if ((in_char >= CH_ZERO) && (in_char <= CH_SEVEN)) begin
                aradix_next = AR_OCT;
                take        = 1'b1;
              end else if (is_x) begin
                aradix_next = AR_HEX;
                phase_next  = PH_DIGITS;
              end else begin
                stopped_next = 1'b1;
              end
            end else if (((radix_mode == MODE_OCT) || (radix_mode == MODE_HEX)) && is_x) begin
              phase_next = PH_DIGITS;
            end else begin
              take = 1'b1;
            end
          end
          default: take = 1'b1;
        endcase
      end
      if (take) begin
        phase_next = PH_DIGITS;
        unique case (radix_mode)
          MODE_BIN: rx = RX_BIN;
          MODE_OCT: rx = RX_OCT;
          MODE_DEC: rx = RX_DEC;
          MODE_HEX: rx = RX_HEX;
          default: begin
            unique case (aradix_next)
              AR_OCT:  rx = RX_OCT;
              AR_DEC:  rx = RX_DEC;
              AR_HEX:  rx = RX_HEX;
              default: rx = RX_NONE;
            endcase
          end
        endcase
        dig = aip_digit(in_char, rx);
        unique case (rx)
          RX_BIN:  acc_scaled = {acc[62:0], 1'b0};
          RX_OCT:  acc_scaled = {acc[60:0], 3'b000};
          RX_DEC:  acc_scaled = {acc[60:0], 3'b000} + {acc[62:0], 1'b0};
          RX_HEX:  acc_scaled = {acc[59:0], 4'b0000};
          default: acc_scaled = acc;
        endcase
        if (dig.ok) begin
          acc_next = acc_scaled + {60'd0, dig.val};
        end else begin
          stopped_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SIGN;
      neg     <= 1'b0;
      acc     <= '0;
      stopped <= 1'b0;
      aradix  <= AR_NONE;
    end else if (proc_fire) begin
      if (in_last) begin
        // number closed, start clean for the next one
        phase   <= PH_SIGN;
        neg     <= 1'b0;
        acc     <= '0;
        stopped <= 1'b0;
        aradix  <= AR_NONE;
      end else begin
        phase   <= phase_next;
        neg     <= neg_next;
        acc     <= acc_next;
        stopped <= stopped_next;
        aradix  <= aradix_next;
      end
    end
  end

  // result stage: one entry per finished number
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else if (fin_ready) begin
      fin_v <= proc_fire && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_last && fin_ready) begin
      // reserved modes give zero
      fin_acc <= reserved ? 64'd0 : acc_next;
      fin_neg <= reserved ? 1'b0 : neg_next;
    end
  end

  // output register, sign applied here
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && fin_v) begin
      m_tdata <= $signed(fin_neg ? (64'd0 - fin_acc) : fin_acc);
    end
  end

endmodule

// File: rtl/aip_checker.sv
module aip_checker (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               s_tlast,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic signed [63:0] m_tdata
);

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing can come out after reset until a byte has passed the input and result registers
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid ##1 !m_tvalid)
    else $error("result right after reset");

  // last byte gives its result through the input, result and output registers when the sink keeps up
  a_last_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("result missing after last byte");

endmodule

bind ascii_integer_parser_unit aip_checker u_aip_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: verif/tb_ascii_integer_parser_unit.sv
`timescale 1ns / 100ps

module tb_ascii_integer_parser_unit;
  import aip_pkg::*;

  // mode codes the block reserves; they must read back a zero value
  localparam logic [2:0] MODE_RSVD_LO = 3'd5;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;

  localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
  localparam int DRAIN_PAD   = 8;       // room for the block's input, result and output registers after its last byte
  localparam int TOTAL_BYTES = 1380;    // directed bytes plus the random bulk

  // parse predictor and the queue of parsed values still owed by the block
  class parse_scoreboard;
    logic [2:0]  radix_mode;
    phase_t      phase;
    logic        negative;
    logic [63:0] total;
    logic        halted;
    aradix_t     found_radix;
    logic [63:0] expected_values[$];
    int          errors;

    function new();
      radix_mode = MODE_AUTO;
      errors     = 0;
      clear_number();
    endfunction

    function void clear_number();
      phase       = PH_SIGN;
      negative    = 1'b0;
      total       = '0;
      halted      = 1'b0;
      found_radix = AR_NONE;
    endfunction

    // value of c as a digit of base, -1 if it is none
    function int digit_of(logic [7:0] c, int base);
      logic [7:0] low;
      low = c | CH_CASE;
      case (base)
        2:  return (c == CH_ZERO || c == CH_ONE) ? int'(c - CH_ZERO) : -1;
        8:  return (c >= CH_ZERO && c <= CH_SEVEN) ? int'(c - CH_ZERO) : -1;
        10: return (c >= CH_ZERO && c <= CH_NINE) ? int'(c - CH_ZERO) : -1;
        16: begin
          if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
          if (low >= CH_LOW_A && low <= CH_LOW_F) return int'(low - HEX_BIAS);
          return -1;
        end
        default: return -1;
      endcase
    endfunction

    function int base_now();
      case (radix_mode)
        MODE_BIN: return 2;
        MODE_OCT: return 8;
        MODE_DEC: return 10;
        MODE_HEX: return 16;
        default: begin
          case (found_radix)
            AR_OCT:  return 8;
            AR_DEC:  return 10;
            AR_HEX:  return 16;
            default: return 0;
          endcase
        end
      endcase
    endfunction

    function void take_digit(logic [7:0] c);
      int base;
      int v;
      base  = base_now();
      v     = digit_of(c, base);
      phase = PH_DIGITS;
      if (v < 0) halted = 1'b1;
      else total = total * 64'(base) + 64'(v);
    endfunction

    function void take_byte(logic [7:0] c);
      logic is_x;
      is_x = ((c | CH_CASE) == CH_LOW_X);
      if (halted) return;
      if (phase == PH_SIGN) begin
        phase = PH_PREFIX;
        if (c == CH_MINUS) begin
          negative = 1'b1;
          return;
        end
        if (c == CH_PLUS) return;
      end
      if (phase == PH_PREFIX) begin
        if (radix_mode == MODE_AUTO) begin
          if (c >= CH_ONE && c <= CH_NINE) begin
            found_radix = AR_DEC;
            take_digit(c);
          end else if (c == CH_ZERO) begin
            phase = PH_ZERO;
          end else begin
            halted = 1'b1;
          end
        end else if (radix_mode == MODE_OCT || radix_mode == MODE_HEX) begin
          if (c == CH_ZERO) phase = PH_ZERO;
          else if (radix_mode == MODE_HEX && c == CH_HASH) phase = PH_DIGITS;
          else take_digit(c);
        end else begin
          take_digit(c);
        end
        return;
      end
      if (phase == PH_ZERO) begin
        if (radix_mode == MODE_AUTO) begin
          if (c >= CH_ZERO && c <= CH_SEVEN) begin
            found_radix = AR_OCT;
            take_digit(c);
          end else if (is_x) begin
            found_radix = AR_HEX;
            phase       = PH_DIGITS;
          end else begin
            halted = 1'b1;
          end
        end else if ((radix_mode == MODE_OCT || radix_mode == MODE_HEX) && is_x) begin
          phase = PH_DIGITS;
        end else begin
          take_digit(c);
        end
        return;
      end
      take_digit(c);
    endfunction

    // one accepted byte request; the last byte of a number owes one value
    function void note_byte(logic [7:0] c, logic last);
      logic reserved;
      reserved = (radix_mode > MODE_HEX);
      if (!reserved) take_byte(c);
      if (last) begin
        if (reserved) expected_values.push_back('0);
        else expected_values.push_back(negative ? -total : total);
        clear_number();
      end
    endfunction

    function void check_value(logic [63:0] v);
      logic [63:0] want;
      if (expected_values.size() == 0) begin
        $display("%0t: parsed_value expected none, actual %h", $time, v);
        errors++;
      end else begin
        want = expected_values.pop_front();
        if (want !== v) begin
          $display("%0t: parsed_value expected %h, actual %h", $time, want, v);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               cfg_we   = 1'b0;
  logic [2:0]         cfg_data = MODE_AUTO;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = '0;
  logic               s_tlast  = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic signed [63:0] m_tdata;

  parse_scoreboard board;
  logic            calm       = 1'b0;  // no idling on either side while set
  int              next_gap   = 0;     // idle cycles before the next byte request
  int              stall_left = 0;
  int              sent_bytes = 0;
  int              cycle_count = 0;

  ascii_integer_parser_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // bytes near the edges of the digit ranges, plus any byte at all
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 15))
      0:  return CH_MINUS;
      1:  return CH_PLUS;
      2:  return CH_HASH;
      3:  return CH_ZERO;
      4:  return CH_ZERO - 8'd1;
      5:  return CH_NINE + 8'd1;
      6:  return CH_LOW_X;
      7:  return CH_LOW_X & ~CH_CASE;
      8:  return CH_LOW_F + 8'd1;
      9:  return CH_LOW_A & ~CH_CASE;
      10: return CH_SEVEN + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_digit(int base);
    int         v;
    logic [7:0] ch;
    v = $urandom_range(0, base - 1);
    if (v < 10) return CH_ZERO + 8'(v);
    ch = CH_LOW_A + 8'(v - 10);
    if ($urandom_range(0, 1)) ch = ch & ~CH_CASE;  // upper case half the time
    return ch;
  endfunction

  // read side: check every accepted value, then pick the next stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_value(m_tdata);
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (!calm) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one byte request; tvalid stays high into the next byte when no gap follows
  task automatic send_char(input logic [7:0] c, input logic last);
    repeat (next_gap) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_byte(c, last);
    sent_bytes++;
    next_gap = calm ? 0 : idle_len();
    if (next_gap > 0) s_tvalid <= 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // drop tvalid and wait for every owed value plus the block's pipeline
  task automatic drain();
    int waited;
    waited = 0;
    // a pending gap has already dropped tvalid
    if (next_gap == 0) s_tvalid <= 1'b0;
    while (board.expected_values.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // radix_mode may only change between numbers, with the block idle
  task automatic set_mode(input logic [2:0] mode);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.radix_mode = mode;
  endtask

  // mostly well formed numbers for the mode, with some junk and broken ones
  task automatic send_random_number(input logic [2:0] mode);
    logic [7:0] text[$];
    int         base;
    int         body_len;
    int         r;
    r    = $urandom_range(0, 99);
    base = 10;
    if (mode > MODE_HEX || r < 12) begin
      repeat ($urandom_range(1, 6)) text.push_back(noise_char());
    end else begin
      case ($urandom_range(0, 3))
        0: text.push_back(CH_MINUS);
        1: text.push_back(CH_PLUS);
        default: ;
      endcase
      case (mode)
        MODE_BIN: base = 2;
        MODE_DEC: base = 10;
        MODE_OCT: begin
          base = 8;
          // optional 0 or 0x lead-in, both skipped
          case ($urandom_range(0, 2))
            0: text.push_back(CH_ZERO);
            1: begin
              text.push_back(CH_ZERO);
              text.push_back($urandom_range(0, 1) ? CH_LOW_X : (CH_LOW_X & ~CH_CASE));
            end
            default: ;
          endcase
        end
        MODE_HEX: begin
          base = 16;
          case ($urandom_range(0, 3))
            0: text.push_back(CH_HASH);
            1: begin
              text.push_back(CH_ZERO);
              text.push_back($urandom_range(0, 1) ? CH_LOW_X : (CH_LOW_X & ~CH_CASE));
            end
            2: text.push_back(CH_ZERO);
            default: ;
          endcase
        end
        default: begin
          // auto: the lead-in picks the radix
          case ($urandom_range(0, 2))
            0: text.push_back(CH_ONE + 8'($urandom_range(0, 8)));
            1: begin
              base = 8;
              text.push_back(CH_ZERO);
            end
            default: begin
              base = 16;
              text.push_back(CH_ZERO);
              text.push_back($urandom_range(0, 1) ? CH_LOW_X : (CH_LOW_X & ~CH_CASE));
            end
          endcase
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < 5) body_len = 0;
      else if (r < 85) body_len = $urandom_range(1, 6);
      else body_len = $urandom_range(7, 24);  // long enough in octal, decimal and hex to wrap 64 bits
      repeat (body_len) text.push_back(pick_digit(base));
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) text.push_back(noise_char());
    end
    if (text.size() == 0) text.push_back(noise_char());
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  initial begin
    logic [2:0] mode;
    int         phase_idx;
    int         phase_start;
    int         budget;
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // auto mode straight out of reset: each radix, a stopped parse, empty digits
    send_text("+42");
    send_text("-0X1f");
    send_text("017");
    send_text("09");
    send_text("-");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    set_mode(MODE_BIN);
    send_text("-10");
    set_mode(MODE_OCT);
    send_text("0x7");
    send_text("07");
    set_mode(MODE_DEC);
    send_text("+9");
    set_mode(MODE_HEX);
    send_text("#F");
    send_text("0xa");
    set_mode(MODE_RSVD_HI);
    send_text("5");

    // random phases, each under one mode, idling switched off now and then
    phase_idx = 0;
    while (sent_bytes < TOTAL_BYTES) begin
      case (phase_idx % 8)
        0: mode = MODE_HEX;
        1: mode = MODE_AUTO;
        2: mode = MODE_BIN;
        3: mode = MODE_OCT;
        4: mode = MODE_DEC;
        5: mode = MODE_RSVD_HI;
        6: mode = MODE_AUTO;
        default: mode = MODE_RSVD_LO;
      endcase
      set_mode(mode);
      calm        = ($urandom_range(0, 3) == 0);
      budget      = (mode > MODE_HEX) ? 30 : 110;
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < budget) send_random_number(mode);
      phase_idx++;
    end

    drain();
    if (board.expected_values.size() != 0) begin
      $display("%0t: %0d parsed values never arrived", $time, board.expected_values.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
